### rtl/core/dltq_pkg.sv
package dltq_pkg;

  localparam int MaxTasks  = 16;
  localparam int ResultCap = 16;
  localparam int IdxW      = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int CntW      = $clog2(MaxTasks + 1);
  localparam int NumW      = $clog2(ResultCap + 1);

  typedef enum logic [1:0] {
    ModeTick     = 2'd0,
    ModeAdd      = 2'd1,
    ModeDelete   = 2'd2,
    ModeDispatch = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KindTicked     = 3'd0,
    KindAdded      = 3'd1,
    KindAddFull    = 3'd2,
    KindDeleted    = 3'd3,
    KindDeleteFail = 3'd4,
    KindDue        = 3'd5,
    KindNoneDue    = 3'd6
  } kind_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] delay_ticks;
    logic [15:0] period_ticks;
    logic [7:0]  task_handle;
    logic [7:0]  task_id;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] result_id;
    logic [7:0] result_handle;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [15:0] delta;
    logic [15:0] period;
    logic [7:0]  id;
    logic [7:0]  handle;
  } entry_t;

  typedef enum logic [1:0] {
    CellNone   = 2'd0,
    CellDec    = 2'd1,
    CellInsert = 2'd2,
    CellRemove = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [IdxW-1:0]  pos;
    entry_t           ent;
  } cell_cmd_t;

endpackage

### rtl/core/dltq_cell.sv
module dltq_cell (
  input  logic               clk_i,
  input  logic [dltq_pkg::IdxW-1:0] idx_i,
  input  dltq_pkg::cell_cmd_t cmd_i,
  input  dltq_pkg::entry_t   prev_i,
  input  dltq_pkg::entry_t   next_i,
  output dltq_pkg::entry_t   own_o
);
  import dltq_pkg::*;

  entry_t          own_q, own_d;
  logic [CntW-1:0] idx_x, pos_x;
  logic [16:0]     sum;

  assign idx_x = CntW'(idx_i);
  assign pos_x = CntW'(cmd_i.pos);
  assign sum   = {1'b0, next_i.delta} + {1'b0, own_q.delta};

  always_comb begin
    own_d = own_q;
    case (cmd_i.op)
      CellDec: begin
        if (idx_x == '0 && own_q.delta != '0) own_d.delta = own_q.delta - 16'd1;
      end
      CellInsert: begin
        if (idx_x == pos_x) begin
          own_d = cmd_i.ent;
        end else if (idx_x > pos_x) begin
          own_d = prev_i;
          // entry right behind the new one gives up the inserted remainder
          if (idx_x == pos_x + CntW'(1)) own_d.delta = prev_i.delta - cmd_i.ent.delta;
        end
      end
      CellRemove: begin
        if (idx_x == pos_x) begin
          own_d = next_i;
          own_d.delta = sum[16] ? 16'hffff : sum[15:0];
        end else if (idx_x > pos_x) begin
          own_d = next_i;
        end
      end
      default: own_d = own_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    own_q <= own_d;
  end

  assign own_o = own_q;
endmodule

### rtl/core/delta_list_task_timer_queue.sv
// delta-list timer queue
// input channel in_valid_i/in_ready_o carries one word per command: tick, add,
// delete or dispatch. output channel out_valid_o/out_ready_i carries result
// words; the last word of a command has last set.
// the queue is a row of cells, one per task slot; on insert and remove the cells
// from the given slot onward shift away from or toward the head together.
// tick and delete go straight from the idle state to their result word. add walks
// the list one cell per cycle, then inserts and emits its word. dispatch removes
// each due task from the head before emitting it, after any periodic reload walk.
// a new command is taken only once the previous one has put its last word
// into the output register; that word may still wait for the receiver.
// when the receiver stalls, the block holds its next word and waits.
// reset empties the queue and clears the id counter; slot contents are
// left as they are and never read before being written.
module delta_list_task_timer_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dltq_pkg::in_t    in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dltq_pkg::out_t   out_data_o
);
  import dltq_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StScan, StDisp, StDrem, StDchk, StEmit
  } state_e;

  state_e          state_q;
  entry_t          ent [MaxTasks];
  entry_t          ent_prev [MaxTasks];
  entry_t          ent_next [MaxTasks];
  cell_cmd_t       cmd;
  logic [CntW-1:0] count_q, pos_q;
  logic [15:0]     rem_q;
  entry_t          nent_q;
  logic [7:0]      idc_q;
  logic [NumW-1:0] num_q;
  logic [1:0]      mode_q;
  logic            more_q, ov_q;
  out_t            res_q, out_q;
  logic            found;
  logic [IdxW-1:0] fpos;
  entry_t          at_pos;
  logic            walk_on;
  logic            emit_fire;

  for (genvar g = 0; g < MaxTasks; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign ent_prev[g] = '0;
    end else begin : g_mid
      assign ent_prev[g] = ent[g-1];
    end
    if (g == MaxTasks - 1) begin : g_last
      assign ent_next[g] = '0;
    end else begin : g_mid2
      assign ent_next[g] = ent[g+1];
    end
    dltq_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (IdxW'(g)),
      .cmd_i  (cmd),
      .prev_i (ent_prev[g]),
      .next_i (ent_next[g]),
      .own_o  (ent[g])
    );
  end

  // first live entry whose id matches
  always_comb begin
    found = 1'b0;
    fpos  = '0;
    for (int i = 0; i < MaxTasks; i++) begin
      if (!found && CntW'(i) < count_q && ent[i].id == in_data_i.task_id) begin
        found = 1'b1;
        fpos  = IdxW'(i);
      end
    end
  end

  assign at_pos    = ent[pos_q[IdxW-1:0]];
  assign walk_on   = (pos_q < count_q) && (rem_q >= at_pos.delta);
  assign emit_fire = (state_q == StEmit) && (!ov_q || out_ready_i);

  always_comb begin
    cmd     = '0;
    cmd.op  = CellNone;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_data_i.mode == ModeTick && count_q != '0) cmd.op = CellDec;
          if (in_data_i.mode == ModeDelete && count_q != '0 && found) begin
            cmd.op  = CellRemove;
            cmd.pos = fpos;
          end
        end
      end
      StScan: begin
        if (!walk_on) begin
          cmd.op        = CellInsert;
          cmd.pos       = pos_q[IdxW-1:0];
          cmd.ent       = nent_q;
          cmd.ent.delta = rem_q;
        end
      end
      StDrem: begin
        cmd.op  = CellRemove;
        cmd.pos = '0;
      end
      default: cmd.op = CellNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      idc_q   <= '0;
      ov_q    <= 1'b0;
      more_q  <= 1'b0;
      num_q   <= '0;
      mode_q  <= '0;
      pos_q   <= '0;
      rem_q   <= '0;
      nent_q  <= '0;
      res_q   <= '0;
      out_q   <= '0;
    end else begin
      if (emit_fire) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            mode_q <= in_data_i.mode;
            more_q <= 1'b0;
            state_q <= StEmit;
            case (in_data_i.mode)
              ModeAdd: begin
                idc_q <= idc_q + 8'd1;
                if (count_q == CntW'(MaxTasks)) begin
                  res_q <= '{kind: KindAddFull, result_id: idc_q + 8'd1,
                             result_handle: 8'd0, last: 1'b1};
                end else begin
                  res_q   <= '{kind: KindAdded, result_id: idc_q + 8'd1,
                               result_handle: 8'd0, last: 1'b1};
                  pos_q   <= '0;
                  rem_q   <= in_data_i.delay_ticks;
                  nent_q  <= '{delta: 16'd0, period: in_data_i.period_ticks,
                               id: idc_q + 8'd1, handle: in_data_i.task_handle};
                  state_q <= StScan;
                end
              end
              ModeDelete: begin
                if (count_q == '0) begin
                  res_q <= '{kind: KindDeleteFail, result_id: 8'd0,
                             result_handle: 8'd0, last: 1'b1};
                end else begin
                  res_q <= '{kind: KindDeleted, result_id: 8'd0,
                             result_handle: 8'd0, last: 1'b1};
                  if (found) count_q <= count_q - CntW'(1);
                end
              end
              ModeDispatch: begin
                num_q   <= '0;
                state_q <= StDisp;
              end
              default: begin
                res_q <= '{kind: KindTicked, result_id: 8'd0, result_handle: 8'd0,
                           last: 1'b1};
              end
            endcase
          end
        end
        StScan: begin
          if (walk_on) begin
            rem_q <= rem_q - at_pos.delta;
            pos_q <= pos_q + CntW'(1);
          end else begin
            count_q <= count_q + CntW'(1);
            if (mode_q == ModeAdd) begin
              state_q <= StEmit;
            end else begin
              state_q <= StDrem;
            end
          end
        end
        StDisp: begin
          if (count_q != '0 && ent[0].delta == '0) begin
            res_q   <= '{kind: KindDue, result_id: ent[0].id,
                         result_handle: ent[0].handle, last: 1'b0};
            state_q <= StDrem;
            if (ent[0].period != '0) begin
              // periodic reload goes in before the due entry leaves
              idc_q <= idc_q + 8'd1;
              if (count_q < CntW'(MaxTasks)) begin
                pos_q   <= '0;
                rem_q   <= ent[0].period;
                nent_q  <= '{delta: 16'd0, period: ent[0].period,
                             id: idc_q + 8'd1, handle: ent[0].handle};
                state_q <= StScan;
              end
            end
          end else begin
            res_q   <= '{kind: KindNoneDue, result_id: 8'd0, result_handle: 8'd0,
                         last: 1'b1};
            more_q  <= 1'b0;
            state_q <= StEmit;
          end
        end
        StDrem: begin
          count_q <= count_q - CntW'(1);
          num_q   <= num_q + NumW'(1);
          state_q <= StDchk;
        end
        StDchk: begin
          more_q     <= (num_q < NumW'(ResultCap)) && count_q != '0 && ent[0].delta == '0;
          res_q.last <= !((num_q < NumW'(ResultCap)) && count_q != '0 && ent[0].delta == '0);
          state_q    <= StEmit;
        end
        StEmit: begin
          if (emit_fire) begin
            out_q   <= res_q;
            state_q <= more_q ? StDisp : StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
endmodule
